[hw/rtl/sfcd_pkg.sv]
package sfcd_pkg;

    localparam int MAX_PAYLOAD   = 64;
    localparam int POS_WIDTH     = 6;
    localparam int LEN_WIDTH     = 7;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int TDATA_WIDTH   = 40;

    // configuration register indexes, the two spare ones are ignored
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SYNC1    = 3'd0,
        REG_SYNC2    = 3'd1,
        REG_POLY     = 3'd2,
        REG_INIT     = 3'd3,
        REG_REFL_IN  = 3'd4,
        REG_REFL_OUT = 3'd5,
        REG_SPARE_6  = 3'd6,
        REG_SPARE_7  = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic crc_feed;
        logic crc_init;
        logic ld_cmd_h;
        logic ld_cmd_l;
        logic ld_len;
        logic clr_len;
        logic wr_payload;
        logic ld_crc_h;
        logic ld_crc_l;
        logic clr_k;
        logic rd_payload;
        logic ld_out_payload;
        logic ld_out_empty;
    } t_cmd;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic len_too_big;
        logic byte_zero;
        logic len_zero;
        logic fill_done;
        logic crc_match;
        logic last_k;
        logic out_free;
    } t_status;

endpackage

[hw/rtl/sfcd_ctrl.sv]
module sfcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sfcd_pkg::t_status i_status,
    output sfcd_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] ST_SYNC1   = 4'd0;
    localparam logic [3:0] ST_SYNC2   = 4'd1;
    localparam logic [3:0] ST_CMD_H   = 4'd2;
    localparam logic [3:0] ST_CMD_L   = 4'd3;
    localparam logic [3:0] ST_LEN     = 4'd4;
    localparam logic [3:0] ST_PAYLOAD = 4'd5;
    localparam logic [3:0] ST_CRC_H   = 4'd6;
    localparam logic [3:0] ST_CRC_L   = 4'd7;
    localparam logic [3:0] ST_CHECK   = 4'd8;
    localparam logic [3:0] ST_EMPTY   = 4'd9;
    localparam logic [3:0] ST_EMIT_RD = 4'd10;
    localparam logic [3:0] ST_EMIT_LD = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    // parse states take one byte per cycle
    assign o_in_ready = (r_state <= ST_CRC_L);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SYNC1;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_SYNC1: begin
                if (w_accept && i_status.is_sync1) begin
                    o_cmd.crc_feed = 1'b1;
                    o_cmd.crc_init = 1'b1;
                    n_state        = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                if (w_accept) begin
                    if (i_status.is_sync2) begin
                        o_cmd.crc_feed = 1'b1;
                        n_state        = ST_CMD_H;
                    end else if (i_status.is_sync1) begin
                        o_cmd.crc_feed = 1'b1;
                        o_cmd.crc_init = 1'b1;
                        n_state        = ST_SYNC2;
                    end else begin
                        n_state = ST_SYNC1;
                    end
                end
            end
            ST_CMD_H: begin
                if (w_accept) begin
                    o_cmd.crc_feed = 1'b1;
                    o_cmd.ld_cmd_h = 1'b1;
                    n_state        = ST_CMD_L;
                end
            end
            ST_CMD_L: begin
                if (w_accept) begin
                    o_cmd.crc_feed = 1'b1;
                    o_cmd.ld_cmd_l = 1'b1;
                    n_state        = ST_LEN;
                end
            end
            ST_LEN: begin
                if (w_accept) begin
                    if (i_status.len_too_big) begin
                        o_cmd.clr_len = 1'b1;
                        n_state       = ST_SYNC1;
                    end else begin
                        o_cmd.crc_feed = 1'b1;
                        o_cmd.ld_len   = 1'b1;
                        n_state        = i_status.byte_zero ? ST_CRC_H : ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (w_accept) begin
                    o_cmd.crc_feed   = 1'b1;
                    o_cmd.wr_payload = 1'b1;
                    if (i_status.fill_done) begin
                        n_state = ST_CRC_H;
                    end
                end
            end
            ST_CRC_H: begin
                if (w_accept) begin
                    o_cmd.ld_crc_h = 1'b1;
                    n_state        = ST_CRC_L;
                end
            end
            ST_CRC_L: begin
                if (w_accept) begin
                    o_cmd.ld_crc_l = 1'b1;
                    n_state        = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_status.crc_match) begin
                    n_state = ST_SYNC1;
                end else if (i_status.len_zero) begin
                    n_state = ST_EMPTY;
                end else begin
                    o_cmd.clr_k = 1'b1;
                    n_state     = ST_EMIT_RD;
                end
            end
            ST_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.ld_out_empty = 1'b1;
                    n_state            = ST_SYNC1;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.rd_payload = 1'b1;
                n_state          = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (i_status.out_free) begin
                    o_cmd.ld_out_payload = 1'b1;
                    n_state = i_status.last_k ? ST_SYNC1 : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_SYNC1;
            end
        endcase
    end

endmodule

[hw/rtl/sfcd_datapath.sv]
module sfcd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_cfg_we,
    input  logic [sfcd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  sfcd_pkg::t_cmd                      i_cmd,
    output sfcd_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sfcd_pkg::TDATA_WIDTH-1:0]    o_out_data,
    output logic                                o_out_user,
    output logic                                o_out_last
);

    localparam int PW = sfcd_pkg::POS_WIDTH;
    localparam int LW = sfcd_pkg::LEN_WIDTH;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] base, input logic [7:0] d,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = base ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // configuration
    logic [7:0]  r_sync1;
    logic [7:0]  r_sync2;
    logic [15:0] r_poly;
    logic [15:0] r_init;
    logic        r_refl_in;
    logic        r_refl_out;

    // frame state
    logic [15:0]   r_crc;
    logic [15:0]   r_cmd_id;
    logic [LW-1:0] r_held_len;
    logic [LW-1:0] r_fill;
    logic [7:0]    r_crc_hi;
    logic [15:0]   r_crc_rx;
    logic [PW-1:0] r_k;

    logic [7:0] r_mem [0:sfcd_pkg::MAX_PAYLOAD-1];
    logic [7:0] r_rd_data;

    // output register
    logic          r_out_valid;
    logic [15:0]   r_out_cmd;
    logic [LW-1:0] r_out_len;
    logic          r_out_has;
    logic [PW-1:0] r_out_pos;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic [15:0]   w_crc_base;
    logic [15:0]   w_crc_next;
    logic [7:0]    w_crc_in;
    logic [15:0]   w_crc_calc;
    logic [LW-1:0] w_fill_inc;
    logic [LW-1:0] w_k_inc;

    assign w_crc_in   = r_refl_in ? rev8(i_rx_byte) : i_rx_byte;
    assign w_crc_base = i_cmd.crc_init ? r_init : r_crc;
    assign w_crc_next = crc_byte(w_crc_base, w_crc_in, r_poly);
    assign w_crc_calc = r_refl_out ? rev16(r_crc) : r_crc;
    assign w_fill_inc = r_fill + LW'(1);
    assign w_k_inc    = {1'b0, r_k} + LW'(1);

    assign o_status.is_sync1    = (i_rx_byte == r_sync1);
    assign o_status.is_sync2    = (i_rx_byte == r_sync2);
    assign o_status.len_too_big = (i_rx_byte > 8'(sfcd_pkg::MAX_PAYLOAD));
    assign o_status.byte_zero   = (i_rx_byte == 8'd0);
    assign o_status.len_zero    = (r_held_len == '0);
    assign o_status.fill_done   = (w_fill_inc >= r_held_len);
    assign o_status.crc_match   = (r_crc_rx == w_crc_calc);
    assign o_status.last_k      = (w_k_inc == r_held_len);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1    <= 8'hAA;
            r_sync2    <= 8'h55;
            r_poly     <= 16'h1021;
            r_init     <= 16'hFFFF;
            r_refl_in  <= 1'b0;
            r_refl_out <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sfcd_pkg::REG_SYNC1:    r_sync1    <= i_cfg_wdata[7:0];
                sfcd_pkg::REG_SYNC2:    r_sync2    <= i_cfg_wdata[7:0];
                sfcd_pkg::REG_POLY:     r_poly     <= i_cfg_wdata;
                sfcd_pkg::REG_INIT:     r_init     <= i_cfg_wdata;
                sfcd_pkg::REG_REFL_IN:  r_refl_in  <= i_cfg_wdata[0];
                sfcd_pkg::REG_REFL_OUT: r_refl_out <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= 16'hFFFF;
            r_held_len <= '0;
            r_fill     <= '0;
            r_k        <= '0;
        end else begin
            if (i_cmd.crc_feed) begin
                r_crc <= w_crc_next;
            end
            if (i_cmd.ld_len) begin
                r_held_len <= i_rx_byte[LW-1:0];
                r_fill     <= '0;
            end else if (i_cmd.clr_len) begin
                r_held_len <= '0;
                r_fill     <= '0;
            end else if (i_cmd.wr_payload) begin
                r_fill <= w_fill_inc;
            end
            if (i_cmd.clr_k) begin
                r_k <= '0;
            end else if (i_cmd.ld_out_payload) begin
                r_k <= w_k_inc[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_cmd_h) begin
            r_cmd_id[15:8] <= i_rx_byte;
        end
        if (i_cmd.ld_cmd_l) begin
            r_cmd_id[7:0] <= i_rx_byte;
        end
        if (i_cmd.ld_crc_h) begin
            r_crc_hi <= i_rx_byte;
        end
        if (i_cmd.ld_crc_l) begin
            r_crc_rx <= {r_crc_hi, i_rx_byte};
        end
    end

    // payload store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_payload) begin
            r_mem[r_fill[PW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_payload) begin
            r_rd_data <= r_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out_payload || i_cmd.ld_out_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out_payload) begin
            r_out_cmd  <= r_cmd_id;
            r_out_len  <= r_held_len;
            r_out_has  <= 1'b1;
            r_out_pos  <= r_k;
            r_out_byte <= r_rd_data;
            r_out_last <= o_status.last_k;
        end else if (i_cmd.ld_out_empty) begin
            r_out_cmd  <= r_cmd_id;
            r_out_len  <= '0;
            r_out_has  <= 1'b0;
            r_out_pos  <= '0;
            r_out_byte <= 8'h00;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {3'b000, r_out_byte, r_out_pos, r_out_len, r_out_cmd};
    assign o_out_user  = r_out_has;
    assign o_out_last  = r_out_last;

endmodule

[hw/rtl/sync_framed_command_deframer_top.sv]
// Frame receiver for a byte stream: hunts for two sync bytes, then takes a big-endian
// command id, a length byte (0 to 64, larger drops the frame), the payload and a
// big-endian CRC-16 over everything before it. Bytes are taken one per cycle while a
// frame is parsed, so a frame of n payload bytes has n + 7 bytes. After the last
// CRC byte the block checks the CRC (a bad frame goes straight back to the sync hunt);
// a good frame then gives one result per payload byte, each made by a registered
// read of the payload memory and then a load of the output register, or a
// single result with tuser low for an empty frame. s_axis_tready stays low from the
// check until the last result is in the output register, also while the output
// register waits on m_axis_tready.
module sync_framed_command_deframer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // command_id, frame_length, byte_position, payload_byte, zero pad
    output logic [sfcd_pkg::TDATA_WIDTH-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser,  // has_payload
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [sfcd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    sfcd_pkg::t_cmd    w_cmd;
    sfcd_pkg::t_status w_status;

    sfcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sfcd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    a_no_emit_while_parsing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && (w_cmd.ld_out_payload || w_cmd.ld_out_empty)))
        else $error("result loaded while input is open");

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.ld_out_payload || w_cmd.ld_out_empty) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    a_empty_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[22:16] == 7'd0))
        else $error("bad empty frame result");

    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            ({1'b0, m_axis_tdata[28:23]} < m_axis_tdata[22:16]))
        else $error("byte position beyond frame length");

endmodule
